// ----- src/slt_pkg.sv -----
// Shared constants, codes and item types of the structured-light triangulator.
// Used by every module of the block; depends on nothing.
package slt_pkg;

	localparam int COEF_W     = 48;
	localparam int COORD_W    = 16;
	localparam int IDX_W      = 6;
	localparam int OUT_W      = 32;
	localparam int NUM_AXES   = 4;
	localparam int TERMS      = 9;
	localparam int NUM_SLOTS  = NUM_AXES * TERMS;
	// homogeneous sums stay below 2^80.1 in magnitude; 82 signed bits hold them
	localparam int HW         = 82;
	localparam int QUOT_BITS  = 32;
	localparam int DIV_STAGES = QUOT_BITS + 1;
	localparam int FIFO_DEPTH = 4;
	localparam int DEF_OUT_FRAC_BITS = 16;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_POINT = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_WZERO   = 2'd2,
		ST_SAT     = 2'd3
	} status_t;

	typedef struct packed {
		logic                     op;
		logic [IDX_W-1:0]         coef_index;
		logic signed [COEF_W-1:0] coef_value;
		logic [COORD_W-1:0]       cam_u;
		logic [COORD_W-1:0]       cam_v;
		logic [COORD_W-1:0]       proj_coord;
		logic                     point_valid;
	} item_t;

endpackage

// ----- src/structured_light_triangulator_core.sv -----
// Top level of the structured-light triangulator: stream ports, APB register,
// front queue, homogeneous-sum pipeline and three dividers. Depends on slt_pkg.
//
// The block takes one beat per clock while its queue has room. A load beat
// (tuser 0) writes one 48-bit coefficient word, slot axis*9+term, and gives no
// result; slots above 35 are dropped. A point beat (tuser 1) gives exactly one
// result beat with x, y, z in signed fixed point with OUT_FRAC_BITS fraction
// bits, and a status in tuser: 0 ok, 1 masked/invalid input (coordinates zero),
// 2 w zero (coordinates zero), 3 at least one axis clipped to the 32-bit range.
// Throughput is one beat per cycle while m_tready holds. A point passes through
// the input queue, the four-stage sum pipeline (coefficient products, projector
// products, sum, magnitudes), the dividers, which resolve one quotient bit per
// stage after an overflow check, and the output register. Beats are taken in
// order, so a load that follows a point never affects that point.
// The whole back end stalls together when a result waits on m_tready; the
// four-entry queue keeps accepting beats meanwhile until it is full. Every
// coefficient slot a point uses must be loaded first. Register 0 (byte address
// 0), bit 0 picks the projector axis: 0 column terms 0..2, 1 row terms 3..5
// (reset 1). Change it only while no beat is in flight.
module structured_light_triangulator_core import slt_pkg::*; #(
	parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// coef_index[5:0], coef_value[53:6], cam_u[69:54], cam_v[85:70],
	// proj_coord[101:86], point_valid[102], zero[103]
	input  logic [103:0] s_tdata,
	// op[0]
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// x_pos[31:0], y_pos[63:32], z_pos[95:64]
	output logic [95:0]  m_tdata,
	// status[1:0]
	output logic [1:0]   m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	localparam int NW = HW + OUT_FRAC_BITS - 1;

	logic mode_q;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {31'b0, mode_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= 1'b1;
		else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
			mode_q <= pwdata[0];
	end

	// input beat unpacking
	item_t in_item, pop_item;
	assign in_item.op          = s_tuser[0];
	assign in_item.coef_index  = s_tdata[5:0];
	assign in_item.coef_value  = $signed(s_tdata[53:6]);
	assign in_item.cam_u       = s_tdata[69:54];
	assign in_item.cam_v       = s_tdata[85:70];
	assign in_item.proj_coord  = s_tdata[101:86];
	assign in_item.point_valid = s_tdata[102];

	// back end advances as one unit unless a result is held
	logic en, pop_valid, pop;
	assign en  = !m_tvalid || m_tready;
	assign pop = en && pop_valid;

	slt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.pop_valid(pop_valid),
		.pop      (pop),
		.pop_item (pop_item)
	);

	logic          vld_s4;
	status_t       status_s4;
	logic [NW-1:0] num_s4 [3];
	logic [HW-2:0] den_s4;
	logic          neg_s4 [3];

	slt_hcalc #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_hcalc (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.mode     (mode_q),
		.pop      (pop),
		.item     (pop_item),
		.vld_s4   (vld_s4),
		.status_s4(status_s4),
		.num_s4   (num_s4),
		.den_s4   (den_s4),
		.neg_s4   (neg_s4)
	);

	logic [OUT_W-1:0] res [3];
	logic             sat [3];

	for (genvar k = 0; k < 3; k++) begin : g_div
		slt_div #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div (
			.clk(clk),
			.en (en),
			.num(num_s4[k]),
			.den(den_s4),
			.neg(neg_s4[k]),
			.res(res[k]),
			.sat(sat[k])
		);
	end

	// status and valid travel alongside the divider stages
	logic    vld_d_q [DIV_STAGES];
	status_t st_d_q  [DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_STAGES; i++)
				vld_d_q[i] <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			vld_d_q[0] <= vld_s4;
			for (int i = 1; i < DIV_STAGES; i++)
				vld_d_q[i] <= vld_d_q[i-1];
			m_tvalid <= vld_d_q[DIV_STAGES-1];
		end
	end

	status_t st_last;
	assign st_last = st_d_q[DIV_STAGES-1];

	always_ff @(posedge clk) begin
		if (en) begin
			st_d_q[0] <= status_s4;
			for (int i = 1; i < DIV_STAGES; i++)
				st_d_q[i] <= st_d_q[i-1];
			if (st_last != ST_OK) begin
				m_tdata <= '0;
				m_tuser <= st_last;
			end else begin
				m_tdata <= {res[2], res[1], res[0]};
				m_tuser <= (sat[0] || sat[1] || sat[2]) ? ST_SAT : ST_OK;
			end
		end
	end

	logic unused_in;
	assign unused_in = s_tdata[103] ^ (^pwdata[31:1]) ^ (^paddr[1:0]);

endmodule

// ----- src/slt_front.sv -----
// Front end: accepts input beats into a short queue ahead of the arithmetic.
// Depends on slt_pkg.
module slt_front import slt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  pop_valid,
	input  logic  pop,
	output item_t pop_item
);
	localparam int PW = $clog2(FIFO_DEPTH);

	item_t         mem_q [FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;
	logic          push, do_pop;

	assign in_ready  = (count_q != (PW+1)'(FIFO_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item  = mem_q[rd_ptr_q];
	assign push      = in_valid & in_ready;
	assign do_pop    = pop & pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (!push && do_pop)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= in_item;
	end

endmodule

// ----- src/slt_hcalc.sv -----
// Back end, first half: coefficient store and the four homogeneous sums.
// Produces numerator and denominator magnitudes for the dividers. Depends on slt_pkg.
module slt_hcalc import slt_pkg::*; #(
	parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       mode,
	input  logic                       pop,
	input  item_t                      item,
	output logic                       vld_s4,
	output status_t                    status_s4,
	output logic [HW+OUT_FRAC_BITS-2:0] num_s4 [3],
	output logic [HW-2:0]              den_s4,
	output logic                       neg_s4 [3]
);
	// one register bank per axis, each word a fixed cell
	logic signed [COEF_W-1:0] coef_q [NUM_AXES][TERMS];

	logic signed [COEF_W-1:0]       a_s1 [NUM_AXES];
	logic signed [COEF_W+COORD_W:0] bu_s1 [NUM_AXES], dv_s1 [NUM_AXES], ep_s1 [NUM_AXES];
	logic signed [COEF_W+COORD_W:0] fu_s1 [NUM_AXES], gv_s1 [NUM_AXES];
	logic signed [COORD_W:0]        p_s1;
	logic                           vld_s1, pv_s1;

	logic signed [COEF_W-1:0]       a_s2 [NUM_AXES];
	logic signed [COEF_W+COORD_W:0] bu_s2 [NUM_AXES], dv_s2 [NUM_AXES], ep_s2 [NUM_AXES];
	logic signed [HW-1:0]           fup_s2 [NUM_AXES], gvp_s2 [NUM_AXES];
	logic                           vld_s2, pv_s2;

	logic signed [HW-1:0] h_s3 [NUM_AXES];
	logic                 vld_s3, pv_s3;

	logic signed [COORD_W:0] u_x, v_x, p_x;
	logic                    load_ok;
	logic [HW-2:0]           mag [NUM_AXES];

	assign u_x     = $signed({1'b0, item.cam_u});
	assign v_x     = $signed({1'b0, item.cam_v});
	assign p_x     = $signed({1'b0, item.proj_coord});
	assign load_ok = pop && (item.op == OP_LOAD) && (item.coef_index < IDX_W'(NUM_SLOTS));

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_AXES; k++) begin
			for (int t = 0; t < TERMS; t++) begin
				if (load_ok && (item.coef_index == IDX_W'(k*TERMS + t)))
					coef_q[k][t] <= item.coef_value;
			end
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_AXES; k++) begin
			mag[k] = h_s3[k][HW-1] ? (HW-1)'(-h_s3[k]) : h_s3[k][HW-2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pop && (item.op == OP_POINT);
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: coefficient times one coordinate
			p_s1  <= p_x;
			pv_s1 <= item.point_valid;
			for (int k = 0; k < NUM_AXES; k++) begin
				a_s1[k]  <= mode ? coef_q[k][3] : coef_q[k][0];
				bu_s1[k] <= (mode ? coef_q[k][4] : coef_q[k][1]) * u_x;
				dv_s1[k] <= (mode ? coef_q[k][5] : coef_q[k][2]) * v_x;
				ep_s1[k] <= coef_q[k][6] * p_x;
				fu_s1[k] <= coef_q[k][7] * u_x;
				gv_s1[k] <= coef_q[k][8] * v_x;
			end
			// stage 2: cross terms times projector coordinate
			pv_s2 <= pv_s1;
			for (int k = 0; k < NUM_AXES; k++) begin
				a_s2[k]   <= a_s1[k];
				bu_s2[k]  <= bu_s1[k];
				dv_s2[k]  <= dv_s1[k];
				ep_s2[k]  <= ep_s1[k];
				fup_s2[k] <= fu_s1[k] * p_s1;
				gvp_s2[k] <= gv_s1[k] * p_s1;
			end
			// stage 3: sum with 24 fraction bits
			pv_s3 <= pv_s2;
			for (int k = 0; k < NUM_AXES; k++) begin
				h_s3[k] <= (HW'(a_s2[k]) <<< 8) - (HW'(bu_s2[k]) <<< 4)
					- (HW'(dv_s2[k]) <<< 4) - (HW'(ep_s2[k]) <<< 4)
					+ fup_s2[k] + gvp_s2[k];
			end
			// stage 4: magnitudes and signs
			if (!pv_s3)
				status_s4 <= ST_INVALID;
			else if (h_s3[3] == '0)
				status_s4 <= ST_WZERO;
			else
				status_s4 <= ST_OK;
			den_s4 <= mag[3];
			for (int k = 0; k < 3; k++) begin
				num_s4[k] <= {mag[k], {OUT_FRAC_BITS{1'b0}}};
				neg_s4[k] <= h_s3[k][HW-1] ^ h_s3[3][HW-1];
			end
		end
	end

endmodule

// ----- src/slt_div.sv -----
// Back end, second half: one-bit-per-stage restoring divider for one axis,
// with overflow check, sign and saturation. Depends on slt_pkg.
module slt_div import slt_pkg::*; #(
	parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [HW+OUT_FRAC_BITS-2:0] num,
	input  logic [HW-2:0]               den,
	input  logic                        neg,
	output logic [OUT_W-1:0]            res,
	output logic                        sat
);
	localparam int NW = HW + OUT_FRAC_BITS - 1;
	localparam int CW = NW + QUOT_BITS;

	logic [NW-1:0]        r_s   [QUOT_BITS+1];
	logic [HW-2:0]        d_s   [QUOT_BITS+1];
	logic [QUOT_BITS-1:0] q_s   [QUOT_BITS+1];
	logic                 ovf_s [QUOT_BITS+1];
	logic                 neg_s [QUOT_BITS+1];

	// stage 0: quotient of 2^32 or more saturates whatever the sign
	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]   <= num;
			d_s[0]   <= den;
			q_s[0]   <= '0;
			neg_s[0] <= neg;
			ovf_s[0] <= CW'(num) >= (CW'(den) << QUOT_BITS);
		end
	end

	for (genvar i = 1; i <= QUOT_BITS; i++) begin : g_stage
		localparam int B = QUOT_BITS - i;
		logic [CW-1:0] dsh;
		logic          ge;
		assign dsh = CW'(d_s[i-1]) << B;
		assign ge  = CW'(r_s[i-1]) >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[i]   <= ge ? NW'(CW'(r_s[i-1]) - dsh) : r_s[i-1];
				d_s[i]   <= d_s[i-1];
				q_s[i]   <= q_s[i-1] | (ge ? (QUOT_BITS'(1) << B) : '0);
				neg_s[i] <= neg_s[i-1];
				ovf_s[i] <= ovf_s[i-1];
			end
		end
	end

	logic [QUOT_BITS-1:0] q, lim;
	assign q   = q_s[QUOT_BITS];
	assign lim = neg_s[QUOT_BITS] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	assign sat = ovf_s[QUOT_BITS] || (q > lim);

	always_comb begin
		if (sat)
			res = lim;
		else
			res = q;
		if (neg_s[QUOT_BITS])
			res = -res;
	end

	logic unused_rem;
	assign unused_rem = ^r_s[QUOT_BITS];

endmodule

// ----- verif/slt_checker.sv -----
// Scoreboard for the structured-light triangulator: watches the stream and APB ports,
// predicts each point result from its own coefficient and mode copy, and compares.
// Depends on slt_pkg.
`timescale 1ns / 100ps

module slt_checker import slt_pkg::*; #(
	parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [103:0] s_tdata,
	input  logic [0:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [95:0]  m_tdata,
	input  logic [1:0]   m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	output int           fails,
	output int           outstanding,
	output int           checked
);

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		status_t     st;
	} point_res_t;

	logic signed [COEF_W-1:0] coef_copy [NUM_SLOTS];
	logic                     axis_mode;
	point_res_t               pending_pts [$];

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: slt_checker mismatch on %s: got %h, expected %h", $realtime, what,
			got, want);
		fails++;
	endtask

	// exact homogeneous sum of one axis, 24 fraction bits
	function automatic logic signed [127:0] axis_sum(input int axis, input logic mode,
			input logic [15:0] u, input logic [15:0] v, input logic [15:0] p);
		logic signed [127:0] ca, cb, cd, ce, cf, cg, uu, vv, pp;
		int b;
		b  = axis * TERMS + (mode ? 3 : 0);
		ca = coef_copy[b];
		cb = coef_copy[b + 1];
		cd = coef_copy[b + 2];
		ce = coef_copy[axis * TERMS + 6];
		cf = coef_copy[axis * TERMS + 7];
		cg = coef_copy[axis * TERMS + 8];
		uu = {112'd0, u};
		vv = {112'd0, v};
		pp = {112'd0, p};
		return (ca <<< 8) - ((cb * uu) <<< 4) - ((cd * vv) <<< 4) - ((ce * pp) <<< 4)
			+ cf * uu * pp + cg * vv * pp;
	endfunction

	function automatic point_res_t triangulate(input logic [15:0] u, input logic [15:0] v,
			input logic [15:0] p, input logic ok);
		point_res_t r;
		logic signed [127:0] h [4];
		logic [127:0] wmag, num, q, limit;
		logic [31:0] o [3];
		logic wneg, neg, sat;
		r = '{x: '0, y: '0, z: '0, st: ST_INVALID};
		if (!ok)
			return r;
		for (int k = 0; k < 4; k++)
			h[k] = axis_sum(k, axis_mode, u, v, p);
		if (h[3] == 0) begin
			r.st = ST_WZERO;
			return r;
		end
		wneg = h[3] < 0;
		wmag = wneg ? -h[3] : h[3];
		sat  = 1'b0;
		for (int k = 0; k < 3; k++) begin
			neg   = (h[k] < 0) != wneg;
			num   = (h[k] < 0) ? -h[k] : h[k];
			num   = num << OUT_FRAC_BITS;
			q     = num / wmag;
			limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
			if (q > limit) begin
				q   = limit;
				sat = 1'b1;
			end
			o[k] = neg ? -q[31:0] : q[31:0];
		end
		r.x  = o[0];
		r.y  = o[1];
		r.z  = o[2];
		r.st = sat ? ST_SAT : ST_OK;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		point_res_t want;
		if (!arst_n) begin
			axis_mode = 1'b1;
			pending_pts.delete();
			fails = 0;
			checked <= 0;
			outstanding <= 0;
		end else begin
			// register write: only byte address 0 exists
			if (psel && penable && pwrite && pready && paddr == 3'd0)
				axis_mode = pwdata[0];
			// result side first, the input side cannot reach it in the same cycle
			if (m_tvalid && m_tready) begin
				checked <= checked + 1;
				if (pending_pts.size() == 0) begin
					$display("%0t: slt_checker: result beat with nothing expected", $realtime);
					fails++;
				end else begin
					want = pending_pts.pop_front();
					if (m_tdata[31:0] !== want.x)
						report("x_pos", m_tdata[31:0], want.x);
					if (m_tdata[63:32] !== want.y)
						report("y_pos", m_tdata[63:32], want.y);
					if (m_tdata[95:64] !== want.z)
						report("z_pos", m_tdata[95:64], want.z);
					if (m_tuser !== want.st)
						report("status", {30'd0, m_tuser}, {30'd0, want.st});
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == OP_LOAD) begin
					if (s_tdata[5:0] < NUM_SLOTS)
						coef_copy[s_tdata[5:0]] = s_tdata[53:6];
				end else begin
					pending_pts.insert(pending_pts.size(), triangulate(s_tdata[69:54],
						s_tdata[85:70], s_tdata[101:86], s_tdata[102]));
				end
			end
			outstanding <= pending_pts.size();
		end
	end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top for the structured-light triangulator: clock, reset, stream and APB
// stimulus, verdict. Depends on slt_pkg, structured_light_triangulator_core, slt_checker.
`timescale 1ns / 100ps

module tb_top;
	import slt_pkg::*;

	localparam int ITEM_TARGET = 1750;
	localparam int DRAIN_CYCLES = 60;	// drain margin beyond the point latency

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// coef_index[5:0], coef_value[53:6], cam_u[69:54], cam_v[85:70],
	// proj_coord[101:86], point_valid[102], zero[103]
	logic [103:0] s_tdata = '0;
	// op[0]
	logic [0:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// x_pos[31:0], y_pos[63:32], z_pos[95:64]
	logic [95:0]  m_tdata;
	// status[1:0]
	logic [1:0]   m_tuser;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	int fails, outstanding, checked;
	int beats_sent;
	int coef_sets;
	bit steady;	// when set neither side idles

	structured_light_triangulator_core DUT (.*);

	slt_checker u_checker (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.fails, .outstanding, .checked
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	// receiver back-pressure: about 27 stalls in a hundred unless steady
	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 27);
	end

	// one beat: optional idle cycles, then hold until the handshake
	task automatic put_beat(input logic op, input logic [5:0] idx, input logic [47:0] coef,
			input logic [15:0] u, input logic [15:0] v, input logic [15:0] p,
			input logic ok);
		while (!steady && $urandom_range(0, 99) < 27) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {1'b0, ok, p, v, u, coef, idx};
		do
			@(posedge clk);
		while (!s_tready);
		beats_sent++;
	endtask

	task automatic load_coef(input int idx, input logic [47:0] coef);
		put_beat(OP_LOAD, idx[5:0], coef, 16'($urandom), 16'($urandom), 16'($urandom),
			1'($urandom));
	endtask

	task automatic put_point(input logic [15:0] u, input logic [15:0] v, input logic [15:0] p,
			input logic ok);
		put_beat(OP_POINT, 6'($urandom), 48'({$urandom, $urandom}), u, v, p, ok);
	endtask

	// wait until every result is back and loads have drained
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// signed word with a random magnitude scale, now and then an extreme
	function automatic logic [47:0] rand_coef();
		logic [63:0] raw;
		int sel;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			return 48'h7FFF_FFFF_FFFF;
		if (sel == 1)
			return 48'h8000_0000_0000;
		if (sel == 2)
			return '0;
		raw = {$urandom, $urandom};
		raw = raw >> $urandom_range(16, 63);
		return ($urandom_range(0, 1) ? -raw[47:0] : raw[47:0]);
	endfunction

	// full reload; w terms may be cleared to force a zero divisor, or made dominant
	task automatic load_set(input bit w_zero);
		logic [47:0] c;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			c = rand_coef();
			if (i >= 3 * TERMS && w_zero)
				c = '0;
			else if ((i == 3 * TERMS || i == 3 * TERMS + 3) && $urandom_range(0, 1))
				c = {8'd0, $urandom, 8'd0};	// big constant w keeps outputs in range
			load_coef(i, c);
		end
		coef_sets++;
	endtask

	initial begin
		int n;
		logic mode;
		steady = 1'b0;
		beats_sent = 0;
		coef_sets = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		load_set(1'b0);
		put_point('1, '1, '1, 1'b0);		// masked point, fields at maximum
		put_point('0, '0, '0, 1'b1);
		put_point('1, '1, '1, 1'b1);
		load_coef(36, 48'h7FFF_FFFF_FFFF);	// slots past 35 are dropped
		load_coef(63, 48'h8000_0000_0000);
		put_point(16'h1234, 16'h0ABC, 16'h4321, 1'b1);
		load_coef(3, 48'h7FFF_FFFF_FFFF);	// huge x constant: clipped high or low
		load_coef(3 * TERMS + 3, 48'd1);	// tiny w
		put_point('0, '0, '0, 1'b1);
		load_coef(3, 48'h8000_0000_0000);
		put_point('0, '0, '0, 1'b1);
		for (int t = 0; t < TERMS; t++)
			load_coef(3 * TERMS + t, '0);	// w axis cleared
		put_point(16'h0100, 16'h0200, 16'h0300, 1'b1);
		settle();
		apb_write(3'd0, 32'hFFFF_FFFE);	// column mode, upper bits ignored
		apb_write(3'd4, 32'h0000_0001);	// no register here
		load_set(1'b0);
		put_point('1, '0, '1, 1'b1);
		put_point('0, '1, '0, 1'b1);
		settle();

		// --- random phases, each with fresh coefficients and mode ---
		for (int ph = 0; beats_sent < ITEM_TARGET; ph++) begin
			settle();
			mode = (ph < 2) ? ph[0] : 1'($urandom_range(0, 1));
			apb_write($urandom_range(0, 7) == 0 ? 3'd4 : 3'd0,
				($urandom & 32'hFFFF_FFFE) | {31'd0, mode});
			steady = (ph == 3);	// one long stretch at full rate both ways
			load_set($urandom_range(0, 7) == 0);
			n = $urandom_range(80, 180);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 99) < 15)
					load_coef($urandom_range(0, 63), rand_coef());
				else
					put_point(16'($urandom), 16'($urandom), 16'($urandom),
						$urandom_range(0, 9) != 0);
			end
			steady = 1'b0;
		end
		settle();

		$display("tb_top: %0d beats sent over %0d coefficient sets, both projector axes",
			beats_sent, coef_sets);
		$display("tb_top: %0d result beats compared, %0d mismatches", checked, fails);
		if (fails == 0 && outstanding == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
src/slt_pkg.sv
src/slt_front.sv
src/slt_hcalc.sv
src/slt_div.sv
src/structured_light_triangulator_core.sv
verif/slt_checker.sv
verif/tb_top.sv
